// File: rtl/sha256bsh_pkg.sv
// Package for the SHA-256 byte stream hasher: types, round constants, initial hash values.
`timescale 1ns / 1ps

package sha256bsh_pkg;

	localparam int unsigned BlockBits = 512;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
		logic [31:0] digest_word5;
		logic [31:0] digest_word6;
		logic [31:0] digest_word7;
	} digest_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_IN,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} src_t;

	typedef struct packed {
		logic shift_en;
		src_t src;
		logic init_en;
		logic round_en;
		logic final_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] round;
	} status_t;

	localparam logic [7:0] PadMark = 8'h80;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428a2f98;
			6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;
			6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;
			6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/sha256bsh_dp.sv
// Datapath: byte/schedule shift register, round logic, chaining words, counters, digest register.
`timescale 1ns / 1ps

module sha256bsh_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              data_byte,
	input  sha256bsh_pkg::cmd_t     cmd,
	output sha256bsh_pkg::status_t  st,
	output sha256bsh_pkg::digest_t  digest
);

	localparam int unsigned BB = sha256bsh_pkg::BlockBits;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [BB-1:0]  blk_q;
	logic [31:0]    wv_q [8];
	logic [31:0]    h_q [8];
	logic [5:0]     fill_q;
	logic [5:0]     round_q;
	logic [60:0]    cnt_q;
	sha256bsh_pkg::digest_t digest_q;

	logic [63:0] bit_len;
	logic [5:0]  len_sh;
	logic [7:0]  byte_in;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] s0, s1, ch, maj, t1, t2;

	assign bit_len = {cnt_q, 3'b000};
	assign len_sh  = {~fill_q[2:0], 3'b000};

	always_comb begin
		case (cmd.src)
			sha256bsh_pkg::SRC_IN:   byte_in = data_byte;
			sha256bsh_pkg::SRC_MARK: byte_in = sha256bsh_pkg::PadMark;
			sha256bsh_pkg::SRC_LEN:  byte_in = bit_len[len_sh +: 8];
			default:                 byte_in = 8'h00;
		endcase
	end

	// window holds w[t..t+15], w[t] in the top word
	assign w0  = blk_q[BB-1 -: 32];
	assign w1  = blk_q[BB-33 -: 32];
	assign w9  = blk_q[BB-1-9*32 -: 32];
	assign w14 = blk_q[BB-1-14*32 -: 32];
	assign w_new = w0 + w9
		+ (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3))
		+ (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

	assign s1  = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
	assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign t1  = wv_q[7] + s1 + ch + sha256bsh_pkg::round_k(round_q) + w0;
	assign s0  = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
	assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t2  = s0 + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[BB-9:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[BB-33:0], w_new};
		end
		if (cmd.init_en) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= h_q[i];
			end
		end else if (cmd.round_en) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
		if (cmd.out_load) begin
			digest_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			round_q <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha256bsh_pkg::InitH[i];
			end
		end else begin
			if (cmd.shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.shift_en && cmd.src == sha256bsh_pkg::SRC_IN) begin
				cnt_q <= cnt_q + 61'd1;
			end else if (cmd.out_load) begin
				cnt_q <= '0;
			end
			if (cmd.init_en) begin
				round_q <= '0;
			end else if (cmd.round_en) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.final_en) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + wv_q[i];
				end
			end else if (cmd.out_load) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= sha256bsh_pkg::InitH[i];
				end
			end
		end
	end

	assign st.fill  = fill_q;
	assign st.round = round_q;
	assign digest   = digest_q;

endmodule

// File: rtl/sha256bsh_ctrl.sv
// Controller: sequences byte intake, compression, padding and the digest request.
`timescale 1ns / 1ps

module sha256bsh_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    msg_valid,
	input  logic                    byte_present,
	input  logic                    last,
	output logic                    msg_stall,
	output logic                    digest_valid,
	input  logic                    digest_stall,
	input  sha256bsh_pkg::status_t  st,
	output sha256bsh_pkg::cmd_t     cmd
);

	sha256bsh_pkg::state_t state_q, state_d;
	logic pad_q, pad_d;       // padding in progress
	logic mark_q, mark_d;     // 0x80 already appended
	logic fin_q, fin_d;       // current block carries the length
	logic out_valid_q, out_valid_d;
	logic accept, fill_top, out_free;

	assign accept   = msg_valid && state_q == sha256bsh_pkg::ST_IDLE;
	assign fill_top = st.fill == 6'd63;
	assign out_free = !out_valid_q || !digest_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256bsh_pkg::ST_IDLE: begin
				if (accept) begin
					if (byte_present && fill_top) begin
						state_d = sha256bsh_pkg::ST_INIT;
					end else if (last) begin
						state_d = sha256bsh_pkg::ST_PAD;
					end
				end
			end
			sha256bsh_pkg::ST_INIT: state_d = sha256bsh_pkg::ST_ROUND;
			sha256bsh_pkg::ST_ROUND: begin
				if (st.round == 6'd63) begin
					state_d = sha256bsh_pkg::ST_FINAL;
				end
			end
			sha256bsh_pkg::ST_FINAL: begin
				if (!pad_q) begin
					state_d = sha256bsh_pkg::ST_IDLE;
				end else if (mark_q && fin_q) begin
					state_d = sha256bsh_pkg::ST_OUT;
				end else begin
					state_d = sha256bsh_pkg::ST_PAD;
				end
			end
			sha256bsh_pkg::ST_PAD: begin
				if (fill_top) begin
					state_d = sha256bsh_pkg::ST_INIT;
				end
			end
			sha256bsh_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = sha256bsh_pkg::ST_IDLE;
				end
			end
			default: state_d = sha256bsh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.src      = sha256bsh_pkg::SRC_IN;
		pad_d        = pad_q;
		mark_d       = mark_q;
		fin_d        = fin_q;
		case (state_q)
			sha256bsh_pkg::ST_IDLE: begin
				cmd.shift_en = accept && byte_present;
				if (accept && last) begin
					pad_d = 1'b1;
				end
			end
			sha256bsh_pkg::ST_INIT: cmd.init_en = 1'b1;
			sha256bsh_pkg::ST_ROUND: cmd.round_en = 1'b1;
			sha256bsh_pkg::ST_FINAL: begin
				cmd.final_en = 1'b1;
				if (pad_q && mark_q) begin
					fin_d = 1'b1;
				end
			end
			sha256bsh_pkg::ST_PAD: begin
				cmd.shift_en = 1'b1;
				if (!mark_q) begin
					cmd.src = sha256bsh_pkg::SRC_MARK;
					mark_d  = 1'b1;
					fin_d   = st.fill[5:3] != 3'b111;
				end else if (fin_q && st.fill[5:3] == 3'b111) begin
					cmd.src = sha256bsh_pkg::SRC_LEN;
				end else begin
					cmd.src = sha256bsh_pkg::SRC_ZERO;
				end
			end
			sha256bsh_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					pad_d        = 1'b0;
					mark_d       = 1'b0;
					fin_d        = 1'b0;
				end
			end
			default: ;
		endcase
		out_valid_d = cmd.out_load || (out_valid_q && digest_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha256bsh_pkg::ST_IDLE;
			pad_q       <= 1'b0;
			mark_q      <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pad_q       <= pad_d;
			mark_q      <= mark_d;
			fin_q       <= fin_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign msg_stall    = state_q != sha256bsh_pkg::ST_IDLE;
	assign digest_valid = out_valid_q;

endmodule

// File: rtl/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
// Usage:
// The msg channel takes one request per byte: data_byte with byte_present set,
// or byte_present clear (an idle request, or an empty closing request when last
// is set). last ends the message; the digest channel then returns one request
// carrying H0..H7, digest_word0 being the most significant word.
// The byte that fills a 64-byte block starts a compression (load, 64 rounds of
// the shared round unit, chaining update), during which no new bytes are taken.
// After last the block appends the pad byte by byte up to the block end (9 to 72
// bytes), compresses one or two blocks and then, in its output state, loads the
// digest register once no stalled digest is pending. msg_stall is high whenever
// the controller is not idle.
// The digest register holds its request while digest_stall is high; new message
// bytes are still taken meanwhile, and only the next digest load waits.
// Reset (arst_n low) clears the controller, counters and the chaining words to
// the initial hash values; no request is pending afterward.

module sha256_byte_stream_hasher_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	output logic                   msg_stall,
	input  sha256bsh_pkg::msg_t    msg,
	output logic                   digest_valid,
	input  logic                   digest_stall,
	output sha256bsh_pkg::digest_t digest
);

	sha256bsh_pkg::cmd_t    cmd;
	sha256bsh_pkg::status_t st;

	sha256bsh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.byte_present (msg.byte_present),
		.last         (msg.last),
		.msg_stall    (msg_stall),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.st           (st),
		.cmd          (cmd)
	);

	sha256bsh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (msg.data_byte),
		.cmd       (cmd),
		.st        (st),
		.digest    (digest)
	);

	a_init_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_en |-> (st.fill == 6'd0 && st.round == 6'd0))
		else $error("compression started without a full block or with a busy round counter");

	a_rounds_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |=> (cmd.round_en || cmd.final_en))
		else $error("round sequence broken before chaining update");

	a_load_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (st.fill == 6'd0 && st.round == 6'd0))
		else $error("digest loaded with a partial block or a busy round counter");

endmodule
